// ===== rtl/core/tksel_pkg.sv =====
// ----------------------------------------------------------------------------
// tksel_pkg
// Shared types and constants for the top-k score selector: the entry held
// by each cell of the chain and the control word broadcast to all cells.
// ----------------------------------------------------------------------------
package tksel_pkg;

    // number of ranks kept, one cell per rank
    localparam int RANK_SLOTS = 10;

    // field widths fixed by the interface
    localparam int VERTEX_W = 32;
    localparam int SCORE_W  = 32;
    localparam int PLACE_W  = 4;

    // one kept entry
    typedef struct packed {
        logic                valid;
        logic [SCORE_W-1:0]  score;
        logic [VERTEX_W-1:0] vertex;
    } entry_t;

    // control broadcast to every cell
    typedef struct packed {
        logic insert;   // a new beat is placed into the sorted chain
        logic shift;    // chain moves one place toward rank 0
    } cell_ctrl_t;

endpackage

// ===== rtl/core/tksel_cell.sv =====
// ----------------------------------------------------------------------------
// tksel_cell
// One rank of the sorted chain. Compares the incoming beat against its own
// entry, and either keeps its entry, takes the new beat, takes the entry of
// the rank above, or takes the entry of the rank below while draining.
// ----------------------------------------------------------------------------
module tksel_cell
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  tksel_pkg::cell_ctrl_t ctrl,
    input  tksel_pkg::entry_t    new_entry,
    input  tksel_pkg::entry_t    prev_entry,
    input  logic                 prev_ahead,
    input  tksel_pkg::entry_t    next_entry,
    output tksel_pkg::entry_t    cur_entry,
    output logic                 ahead
);
    import tksel_pkg::*;

    logic                valid_reg;
    logic                valid_next;
    logic [SCORE_W-1:0]  score_reg;
    logic [SCORE_W-1:0]  score_next;
    logic [VERTEX_W-1:0] vertex_reg;
    logic [VERTEX_W-1:0] vertex_next;
    entry_t              pick;

    // new beat ranks strictly ahead of this entry, or the slot is empty
    assign ahead = !valid_reg
                || (new_entry.score > score_reg)
                || ((new_entry.score == score_reg) && (new_entry.vertex < vertex_reg));

    assign cur_entry = '{valid: valid_reg, score: score_reg, vertex: vertex_reg};

    // choose what this rank holds next
    always_comb
    begin
        pick = cur_entry;
        if (ctrl.shift)
        begin
            pick = next_entry;
        end
        else if (ctrl.insert && ahead)
        begin
            if (prev_ahead)
            begin
                pick = prev_entry;
            end
            else
            begin
                pick = new_entry;
            end
        end
        valid_next  = pick.valid;
        score_next  = pick.score;
        vertex_next = pick.vertex;
    end

    // occupancy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // entry payload
    always_ff @(posedge clk)
    begin
        score_reg  <= score_next;
        vertex_reg <= vertex_next;
    end

endmodule

// ===== rtl/core/top_k_score_select.sv =====
// Output: the final beat is inserted at acceptance; the sequencer then enters
//   ST_DRAIN and loads rank 0 into the output registers, then one rank per cycle while out_ready stays high.
// Throughput: one input beat per cycle while filling, set by the single
//   compare-and-shift step of the cell chain; input stalls during the drain
//   of up to RANK_SLOTS ranks after a final beat.
// Reset: all cells empty, no result pending, ready to accept input.
// ----------------------------------------------------------------------------
// top_k_score_select
// Streaming top-k selector built as a chain of compare-and-shift cells.
// Keeps the best RANK_SLOTS (vertex, score) pairs and emits them in rank
// order when a beat marked final arrives.
// ----------------------------------------------------------------------------
module top_k_score_select
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [tksel_pkg::VERTEX_W-1:0] vertex_number,
    input  logic [tksel_pkg::SCORE_W-1:0]  rank_score,
    input  logic                           final_item,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [tksel_pkg::PLACE_W-1:0]  place,
    output logic [tksel_pkg::VERTEX_W-1:0] best_vertex,
    output logic [tksel_pkg::SCORE_W-1:0]  best_score,
    output logic                           run_end
);
    import tksel_pkg::*;

    typedef enum logic [0:0] {
        ST_FILL,
        ST_DRAIN
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [PLACE_W-1:0]  cnt_reg;
    logic [PLACE_W-1:0]  cnt_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [PLACE_W-1:0]  place_reg;
    logic [PLACE_W-1:0]  place_next;
    logic [VERTEX_W-1:0] vertex_reg;
    logic [VERTEX_W-1:0] vertex_next;
    logic [SCORE_W-1:0]  score_reg;
    logic [SCORE_W-1:0]  score_next;
    logic                run_end_reg;
    logic                run_end_next;

    cell_ctrl_t          ctrl;
    entry_t              new_entry;
    entry_t              links [RANK_SLOTS+1];
    logic                aheads [RANK_SLOTS];
    logic                last_rank;

    // handshake and chain control
    assign in_ready    = (state_reg == ST_FILL);
    assign ctrl.insert = in_valid && in_ready;
    assign ctrl.shift  = (state_reg == ST_DRAIN) && links[0].valid
                      && (!out_valid_reg || out_ready);
    assign new_entry   = '{valid: 1'b1, score: rank_score, vertex: vertex_number};

    // empty entry feeds the tail while draining
    assign links[RANK_SLOTS] = '{valid: 1'b0, score: '0, vertex: '0};

    // rank 0 leaves with nothing behind it
    assign last_rank = !links[1].valid;

    // the cell chain
    genvar gi;
    generate
        for (gi = 0; gi < RANK_SLOTS; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                tksel_cell u_cell
                (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctrl       (ctrl),
                    .new_entry  (new_entry),
                    .prev_entry (new_entry),
                    .prev_ahead (1'b0),
                    .next_entry (links[gi+1]),
                    .cur_entry  (links[gi]),
                    .ahead      (aheads[gi])
                );
            end
            else
            begin : g_body
                tksel_cell u_cell
                (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctrl       (ctrl),
                    .new_entry  (new_entry),
                    .prev_entry (links[gi-1]),
                    .prev_ahead (aheads[gi-1]),
                    .next_entry (links[gi+1]),
                    .cur_entry  (links[gi]),
                    .ahead      (aheads[gi])
                );
            end
        end
    endgenerate

    // sequencer next state and output register load
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        place_next     = place_reg;
        vertex_next    = vertex_reg;
        score_next     = score_reg;
        run_end_next   = run_end_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_FILL:
            begin
                if (ctrl.insert && final_item)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (ctrl.shift)
                begin
                    out_valid_next = 1'b1;
                    place_next     = cnt_reg;
                    vertex_next    = links[0].vertex;
                    score_next     = links[0].score;
                    run_end_next   = last_rank;
                    if (last_rank)
                    begin
                        cnt_next   = '0;
                        state_next = ST_FILL;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + PLACE_W'(1);
                    end
                end
                else if (!links[0].valid)
                begin
                    cnt_next   = '0;
                    state_next = ST_FILL;
                end
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            place_reg     <= '0;
            vertex_reg    <= '0;
            score_reg     <= '0;
            run_end_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            place_reg     <= place_next;
            vertex_reg    <= vertex_next;
            score_reg     <= score_next;
            run_end_reg   <= run_end_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign place       = place_reg;
    assign best_vertex = vertex_reg;
    assign best_score  = score_reg;
    assign run_end     = run_end_reg;

endmodule

// ===== tb/tb_top_k_score_select.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top_k_score_select
// Self-checking bench for the streaming top-k selector. Streams of
// (vertex, score) beats are pushed in with random gaps, ranked beats are
// pulled out with random stalls, and each output beat is compared with a
// sorted-store model kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module tb_top_k_score_select;

    import tksel_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int RESET_CYC   = 7;
    localparam int RANDOM_GOAL = 200;
    localparam int CALM_TAIL   = 40;
    localparam int CYCLE_LIMIT = 200000;

    // one expected output beat
    typedef struct {
        logic [PLACE_W-1:0]  place;
        logic [VERTEX_W-1:0] vertex;
        logic [SCORE_W-1:0]  score;
        logic                run_end;
    } rank_beat_t;

    // sorted-store model plus queue of ranked beats still owed by the block
    class rank_scoreboard;
        logic [SCORE_W-1:0]  kept_score[RANK_SLOTS];
        logic [VERTEX_W-1:0] kept_vertex[RANK_SLOTS];
        bit                  kept_valid[RANK_SLOTS];
        int                  kept_n;
        rank_beat_t          owed[$];
        int                  errors;
        int                  checked;
        int                  streams;

        function new();
            clear_store();
            errors  = 0;
            checked = 0;
            streams = 0;
        endfunction

        function void clear_store();
            for (int i = 0; i < RANK_SLOTS; i++) begin
                kept_score[i]  = '0;
                kept_vertex[i] = '0;
                kept_valid[i]  = 1'b0;
            end
            kept_n = 0;
        endfunction

        // higher score wins, lower vertex breaks a tie
        function bit outranks(logic [SCORE_W-1:0] sa, logic [VERTEX_W-1:0] va,
                              logic [SCORE_W-1:0] sb, logic [VERTEX_W-1:0] vb);
            if (sa != sb)
                return sa > sb;
            return va < vb;
        endfunction

        function void place_pair(logic [VERTEX_W-1:0] vertex, logic [SCORE_W-1:0] score);
            int pos;
            int last;
            pos = 0;
            // walk past every entry the new pair does not beat
            while (pos < kept_n && kept_valid[pos] &&
                   !outranks(score, vertex, kept_score[pos], kept_vertex[pos]))
                pos++;
            if (pos >= RANK_SLOTS)
                return;
            last = (kept_n < RANK_SLOTS) ? kept_n : RANK_SLOTS - 1;
            for (int i = last; i > pos; i--) begin
                kept_score[i]  = kept_score[i-1];
                kept_vertex[i] = kept_vertex[i-1];
                kept_valid[i]  = kept_valid[i-1];
            end
            kept_score[pos]  = score;
            kept_vertex[pos] = vertex;
            kept_valid[pos]  = 1'b1;
            if (kept_n < RANK_SLOTS)
                kept_n++;
        endfunction

        // accepted input beat: insert, and on the final beat queue the ranking
        function void note_beat(logic [VERTEX_W-1:0] vertex, logic [SCORE_W-1:0] score,
                                logic fin);
            rank_beat_t rb;
            place_pair(vertex, score);
            if (fin) begin
                for (int k = 0; k < kept_n; k++) begin
                    rb.place   = k[PLACE_W-1:0];
                    rb.vertex  = kept_vertex[k];
                    rb.score   = kept_score[k];
                    rb.run_end = (k == kept_n - 1);
                    owed.push_back(rb);
                end
                streams++;
                clear_store();
            end
        endfunction

        task report_mismatch(string what);
            $display("[%0t] mismatch: %s", $time, what);
            errors++;
        endtask

        // accepted output beat against the oldest owed ranking
        task check_result(logic [PLACE_W-1:0] place, logic [VERTEX_W-1:0] vertex,
                          logic [SCORE_W-1:0] score, logic run_end);
            rank_beat_t rb;
            if (owed.size() == 0) begin
                report_mismatch($sformatf("unexpected rank beat place=%0d vertex=%h",
                                          place, vertex));
            end
            else begin
                rb = owed.pop_front();
                checked++;
                if (place !== rb.place)
                    report_mismatch($sformatf("place got %0d want %0d", place, rb.place));
                if (vertex !== rb.vertex)
                    report_mismatch($sformatf("vertex at place %0d got %h want %h",
                                              rb.place, vertex, rb.vertex));
                if (score !== rb.score)
                    report_mismatch($sformatf("score at place %0d got %h want %h",
                                              rb.place, score, rb.score));
                if (run_end !== rb.run_end)
                    report_mismatch($sformatf("run_end at place %0d got %b want %b",
                                              rb.place, run_end, rb.run_end));
            end
        endtask
    endclass

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [VERTEX_W-1:0] vertex_number;
    logic [SCORE_W-1:0]  rank_score;
    logic                final_item;
    logic                out_valid;
    logic                out_ready;
    logic [PLACE_W-1:0]  place;
    logic [VERTEX_W-1:0] best_vertex;
    logic [SCORE_W-1:0]  best_score;
    logic                run_end;

    rank_scoreboard sb;
    bit             calm;
    bit             gaps_on;
    int             beats_sent;
    int             cycle_count;

    top_k_score_select u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .vertex_number (vertex_number),
        .rank_score    (rank_score),
        .final_item    (final_item),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .place         (place),
        .best_vertex   (best_vertex),
        .best_score    (best_score),
        .run_end       (run_end)
    );

    // clock and known input levels from time zero
    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        vertex_number = '0;
        rank_score    = '0;
        final_item    = 1'b0;
        out_ready     = 1'b0;
        calm          = 1'b0;
        gaps_on       = 1'b0;
        beats_sent    = 0;
        cycle_count   = 0;
        sb            = new();
    end

    always #CLK_HALF clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d ranks still owed",
                     cycle_count, sb.owed.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // both handshakes sampled at the edge, input side first
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_beat(vertex_number, rank_score, final_item);
        if (rst_n && out_valid && out_ready)
            sb.check_result(place, best_vertex, best_score, run_end);
    end

    // output side: ready bursts broken by random stalls, steady in the tail
    initial
    begin
        int stall;
        int run;
        @(posedge clk);
        forever
        begin
            if (calm)
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                stall = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 17) : 0;
                run   = $urandom_range(1, 20);
                if (stall > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                out_ready <= 1'b1;
                repeat (run) @(posedge clk);
            end
        end
    end

    // one input beat, optionally after an idle burst
    task send_beat(input logic [VERTEX_W-1:0] v, input logic [SCORE_W-1:0] s,
                   input logic fin);
        int gap;
        gap = 0;
        if (!calm && gaps_on && $urandom_range(0, 2) == 0)
            gap = $urandom_range(1, 17);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        vertex_number <= v;
        rank_score    <= s;
        final_item    <= fin;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        beats_sent++;
    endtask

    // random stream; modes narrow the value ranges to force ties and repeats
    task send_random_stream(input int len);
        int                  vmode;
        int                  smode;
        logic [VERTEX_W-1:0] v;
        logic [SCORE_W-1:0]  s;
        logic [VERTEX_W-1:0] prev_v;
        logic [SCORE_W-1:0]  prev_s;
        vmode  = $urandom_range(0, 2);
        smode  = $urandom_range(0, 3);
        prev_v = '0;
        prev_s = '0;
        for (int i = 0; i < len; i++)
        begin
            case (vmode)
                0:       v = $urandom();
                1:       v = $urandom_range(0, 15);
                default: v = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 7)
                                                         : ~VERTEX_W'($urandom_range(0, 7));
            endcase
            case (smode)
                0:       s = $urandom();
                1:       s = $urandom_range(0, 7);
                2:       s = ($urandom_range(0, 1) == 0) ? '0 : '1;
                default: s = {2'($urandom_range(0, 3)), 30'($urandom())};
            endcase
            // identical pair now and then
            if (i > 0 && $urandom_range(0, 7) == 0)
            begin
                v = prev_v;
                s = prev_s;
            end
            send_beat(v, s, i == len - 1);
            prev_v = v;
            prev_s = s;
        end
    endtask

    // main sequence
    initial
    begin
        int directed_beats;
        int len;
        repeat (RESET_CYC) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // lone final beat straight after reset
        send_beat('0, '0, 1'b1);

        // extremes, score tie, identical pair, repeated vertex
        send_beat('1, '1, 1'b0);
        send_beat('0, '1, 1'b0);
        send_beat(32'h0000_0005, 32'h8000_0000, 1'b0);
        send_beat(32'h0000_0005, 32'h8000_0000, 1'b0);
        send_beat(32'h0000_0005, 32'h0000_0001, 1'b1);

        // overfill: later low beats drop out, a late best beat still gets in
        gaps_on = 1'b1;
        for (int i = 0; i < 11; i++)
            send_beat(VERTEX_W'(i + 100), SCORE_W'(1000 - 10 * i), 1'b0);
        send_beat(32'h0000_0001, '0, 1'b0);
        send_beat(32'hFFFF_FFFE, '1, 1'b1);
        directed_beats = beats_sent;

        // random streams, mostly short, a few well past the store size
        while (beats_sent < directed_beats + RANDOM_GOAL)
        begin
            if (beats_sent >= directed_beats + RANDOM_GOAL - CALM_TAIL)
                calm = 1'b1;
            gaps_on = ($urandom_range(0, 2) != 0);
            if ($urandom_range(0, 4) == 0)
                len = $urandom_range(RANK_SLOTS + 1, 3 * RANK_SLOTS);
            else
                len = $urandom_range(1, RANK_SLOTS);
            send_random_stream(len);
        end
        in_valid <= 1'b0;

        // drain, then let any stray beat show up
        while (sb.owed.size() != 0) @(posedge clk);
        repeat (4 * RANK_SLOTS) @(posedge clk);

        $display("%0d input beats in %0d streams, %0d ranked beats compared",
                 beats_sent, sb.streams, sb.checked);
        $display("covered ties, identical pairs, overfilled stores and random stalls");
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== top_k_score_select.f =====
rtl/core/tksel_pkg.sv
rtl/core/tksel_cell.sv
rtl/core/top_k_score_select.sv
tb/tb_top_k_score_select.sv
